@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/dtp_tlv_pkg.sv @@
`timescale 1ns / 1ps

package dtp_tlv_pkg;

  localparam int unsigned DtpMaxPayloadBytes = 2048;

  // TLV header is a 16-bit type followed by a 16-bit length, both big-endian.
  localparam int unsigned HdrBytes  = 4;
  localparam int unsigned MacBytes  = 6;
  localparam int unsigned MacCntW   = 3;
  localparam int unsigned DomOffW   = 11;
  localparam int unsigned DomOffMax = 2047;

  typedef logic [15:0] tlv_type_t;

  localparam tlv_type_t TlvEnd       = 16'd0;
  localparam tlv_type_t TlvDomain    = 16'd1;
  localparam tlv_type_t TlvStatus    = 16'd2;
  localparam tlv_type_t TlvTrunkType = 16'd3;
  localparam tlv_type_t TlvNeighbor  = 16'd4;

  // Summary of one frame; the first member sits in the highest bits.
  typedef struct packed {
    logic               malformed;
    logic [DomOffW-1:0] domain_offset;
    logic               domain_present;
    logic [47:0]        neighbor_mac;
    logic [3:0]         type_oper;
    logic [3:0]         type_admin;
    logic [3:0]         status_oper;
    logic [3:0]         status_admin;
    logic [7:0]         version;
  } result_t;

  localparam int unsigned ResultW  = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

@@ rtl/dtp_tlv_frame_parser.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Parses a trunking-negotiation payload streamed one byte per beat, version
// byte first, and returns one summary beat per frame (version, status and
// trunk-type nibbles, neighbor address, domain string offset, malformed flag)
// for the input beat that carries tlast. A byte is taken on every cycle: the
// whole per-byte update is one pass of logic into the running TLV state, and
// the summary is held in an output register until it is taken. The summary
// is registered and appears in the cycle after its last byte is accepted;
// the input stalls only while a summary is held and m_axis_tready is low.
// Bytes at offsets of MAX_PAYLOAD_BYTES or beyond are ignored but the last
// mark still closes the frame.
module dtp_tlv_frame_parser
  import dtp_tlv_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = DtpMaxPayloadBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tlast,  // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] version, [11:8] status_admin, [15:12] status_oper, [19:16] type_admin,
  // [23:20] type_oper, [71:24] neighbor_mac, [72] domain_present,
  // [83:73] domain_offset, [84] malformed, rest zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned OffW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned CmpW = (OffW > 16) ? OffW : 16;
  localparam int unsigned SumW = ((OffW + 1) > DomOffW) ? (OffW + 1) : DomOffW;

  logic [OffW-1:0]    off_q, off_d;
  logic [OffW-1:0]    start_q, start_d;
  logic [31:0]        hdr_q, hdr_d;
  logic               stopped_q, stopped_d;
  logic               malformed_q, malformed_d;
  logic [7:0]         ver_q, ver_d;
  logic [7:0]         stat_q, stat_d;
  logic [7:0]         ttype_q, ttype_d;
  logic               dom_p_q, dom_p_d;
  logic [DomOffW-1:0] dom_off_q, dom_off_d;
  logic [47:0]        mac_q, mac_d;
  logic [MacCntW-1:0] mac_cnt_q, mac_cnt_d;

  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               s_acc;
  logic [OffW-1:0]    rel;
  logic [OffW-1:0]    rel_eff;
  logic               wrap;
  logic [31:0]        hdr_new;
  tlv_type_t          new_type;
  logic [15:0]        new_len;
  tlv_type_t          cur_type;
  logic [SumW-1:0]    dom_sum;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign rel      = off_q - start_q;
  assign wrap     = (rel >= OffW'(HdrBytes)) && (hdr_q[15:0] >= 16'(HdrBytes)) &&
                    (CmpW'(rel) >= CmpW'(hdr_q[15:0]));
  assign rel_eff  = wrap ? '0 : rel;
  assign hdr_new  = {hdr_q[23:0], s_axis_tdata};
  assign new_type = hdr_new[31:16];
  assign new_len  = hdr_new[15:0];
  assign cur_type = hdr_q[31:16];
  assign dom_sum  = SumW'(start_q) + SumW'(HdrBytes);

  always_comb begin
    off_d       = off_q;
    start_d     = start_q;
    hdr_d       = hdr_q;
    stopped_d   = stopped_q;
    malformed_d = malformed_q;
    ver_d       = ver_q;
    stat_d      = stat_q;
    ttype_d     = ttype_q;
    dom_p_d     = dom_p_q;
    dom_off_d   = dom_off_q;
    mac_d       = mac_q;
    mac_cnt_d   = mac_cnt_q;

    if (s_acc) begin
      if (off_q == '0) begin
        ver_d = s_axis_tdata;
      end else if (!stopped_q && (off_q < OffW'(MAX_PAYLOAD_BYTES))) begin
        if (wrap) begin
          start_d = off_q;
        end
        if (rel_eff < OffW'(HdrBytes)) begin
          hdr_d = hdr_new;
          // The header is complete on its fourth byte; only then act on it.
          if (rel_eff == OffW'(HdrBytes - 1)) begin
            if (new_type == TlvEnd) begin
              stopped_d = 1'b1;
            end else if ((new_len != 16'd0) && (new_len < 16'(HdrBytes))) begin
              malformed_d = 1'b1;
              stopped_d   = 1'b1;
            end else begin
              priority if (new_type == TlvDomain) begin
                dom_p_d   = 1'b1;
                dom_off_d = (dom_sum > SumW'(DomOffMax)) ? DomOffW'(DomOffMax)
                                                         : DomOffW'(dom_sum);
              end else if (new_type == TlvStatus) begin
                stat_d = '0;
              end else if (new_type == TlvTrunkType) begin
                ttype_d = '0;
              end else if (new_type == TlvNeighbor) begin
                mac_d     = '0;
                mac_cnt_d = '0;
              end else begin
              end
            end
          end
        end else begin
          priority if ((cur_type == TlvStatus) && (rel_eff == OffW'(HdrBytes))) begin
            stat_d = s_axis_tdata;
          end else if ((cur_type == TlvTrunkType) && (rel_eff == OffW'(HdrBytes))) begin
            ttype_d = s_axis_tdata;
          end else if ((cur_type == TlvNeighbor) &&
                       (rel_eff < OffW'(HdrBytes + MacBytes))) begin
            mac_d     = {mac_q[39:0], s_axis_tdata};
            mac_cnt_d = mac_cnt_q + MacCntW'(1);
          end else begin
          end
        end
      end
      if (off_q < OffW'(MAX_PAYLOAD_BYTES)) begin
        off_d = off_q + OffW'(1);
      end
    end
  end

  // Summary built from the state as updated by the closing byte.
  always_comb begin
    res_d                = res_q;
    res_d.version        = ver_d;
    res_d.status_admin   = stat_d[3:0];
    res_d.status_oper    = stat_d[7:4];
    res_d.type_admin     = ttype_d[3:0];
    res_d.type_oper      = ttype_d[7:4];
    res_d.neighbor_mac   = (mac_cnt_d == MacCntW'(MacBytes)) ? mac_d : '0;
    res_d.domain_present = dom_p_d;
    res_d.domain_offset  = dom_off_d;
    res_d.malformed      = malformed_d;

    if (s_acc && s_axis_tlast) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      start_q     <= OffW'(1);
      hdr_q       <= '0;
      stopped_q   <= 1'b0;
      malformed_q <= 1'b0;
      ver_q       <= '0;
      stat_q      <= '0;
      ttype_q     <= '0;
      dom_p_q     <= 1'b0;
      dom_off_q   <= '0;
      mac_q       <= '0;
      mac_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_acc && s_axis_tlast) begin
        // The frame is closed: start over for the next one.
        off_q       <= '0;
        start_q     <= OffW'(1);
        hdr_q       <= '0;
        stopped_q   <= 1'b0;
        malformed_q <= 1'b0;
        ver_q       <= '0;
        stat_q      <= '0;
        ttype_q     <= '0;
        dom_p_q     <= 1'b0;
        dom_off_q   <= '0;
        mac_q       <= '0;
        mac_cnt_q   <= '0;
      end else begin
        off_q       <= off_d;
        start_q     <= start_d;
        hdr_q       <= hdr_d;
        stopped_q   <= stopped_d;
        malformed_q <= malformed_d;
        ver_q       <= ver_d;
        stat_q      <= stat_d;
        ttype_q     <= ttype_d;
        dom_p_q     <= dom_p_d;
        dom_off_q   <= dom_off_d;
        mac_q       <= mac_d;
        mac_cnt_q   <= mac_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

  `ASSERT_NEXT(a_last_restarts, clk_i, rst_ni, s_acc && s_axis_tlast, off_q == '0, "offset not cleared after last beat")
  `ASSERT_IMPLIES(a_start_behind, clk_i, rst_ni, off_q != '0, start_q <= off_q, "TLV start ahead of byte offset")
  `ASSERT_ALWAYS(a_mac_count, clk_i, rst_ni, mac_cnt_q <= MacCntW'(MacBytes), "neighbor byte count overran")
  `ASSERT_IMPLIES(a_malformed_stops, clk_i, rst_ni, malformed_q, stopped_q, "malformed TLV did not stop parsing")
  `ASSERT_IMPLIES(a_result_source, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_acc && s_axis_tlast), "summary beat without a last input beat")

endmodule
